// ===== design/hvt_pkg.sv =====
// shared types and constants of the histogram valley threshold block
// no dependencies; compile first
package hvt_pkg;

    localparam int PIXEL_W  = 8;
    localparam int LEVEL_W  = 8;
    localparam int THRESH_W = 9;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W    = 32;

    localparam logic [CFG_W-1:0] BRIGHT_LEVEL_RST  = 8'd120;
    localparam logic [CFG_W-1:0] BRIGHT_OFFSET_RST = 8'd25;
    localparam logic [CFG_W-1:0] DARK_OFFSET_RST   = 8'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_OFFSET   = 2'd2;

    typedef logic [LEVEL_W-1:0] t_level;

endpackage

// ===== design/hvt_pix_if.sv =====
// pixel and result channel interfaces
// depends on hvt_pkg
interface hvt_pix_if;
    import hvt_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               last;
    modport source (output valid, output pixel, output last, input ready);
    modport sink (input valid, input pixel, input last, output ready);
endinterface

interface hvt_res_if;
    import hvt_pkg::*;
    logic                valid;
    logic                ready;
    logic [THRESH_W-1:0] threshold_half;
    t_level              mean_level;
    t_level              median_level;
    t_level              low_peak;
    t_level              high_peak;
    t_level              valley;
    logic                overflow;
    modport source (output valid, output threshold_half, output mean_level,
                    output median_level, output low_peak, output high_peak,
                    output valley, output overflow, input ready);
    modport sink (input valid, input threshold_half, input mean_level,
                  input median_level, input low_peak, input high_peak,
                  input valley, input overflow, output ready);
endinterface

// ===== design/hvt_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module hvt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/histogram_valley_threshold_core.sv =====
// histogram valley threshold core: histogram build, mean, median, peaks, valley
// depends on hvt_pkg, hvt_pix_if, hvt_res_if, hvt_ram
//
// channel   dir  handshake      payload
// i_pix     in   valid/ready    pixel, last
// o_res     out  valid/ready    threshold_half, mean_level, median_level,
//                               low_peak, high_peak, valley, overflow
// i_cfg     in   write enable   i_cfg_idx, i_cfg_data
//
// each pixel gets a histogram ram read, then a read-modify-write back before the next is taken
// a last pixel adds the divider pass for the mean, the median scan, the
// three peak/valley scans over the bins that each one visits, and a clearing
// pass through every bin of the histogram ram
// after reset the same clearing pass runs before the first pixel is taken
// the result sits in an output register; a stalled result holds back only the
// next image's result, the core waits at image end until it is taken
module histogram_valley_threshold_core #(
    parameter int BINS        = 256,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    hvt_pix_if.sink                  i_pix,
    hvt_res_if.source                o_res,
    input  logic                     i_cfg_we,
    input  logic [hvt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hvt_pkg::CFG_W-1:0]     i_cfg_data
);
    import hvt_pkg::*;

    localparam int IW   = $clog2(BINS);
    localparam int CW   = COUNT_WIDTH;
    localparam int CUMW = CW + IW + 1;
    localparam int PW   = (IW > PIXEL_W) ? IW : PIXEL_W;
    localparam int EW   = ((IW > 9) ? IW : 9) + 2;
    localparam int MEAN_MAX = (BINS - 1 < 255) ? BINS - 1 : 255;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_WR, S_DIV, S_MRD, S_MEV, S_LIM, S_SRD, S_SEV, S_FIN
    } t_state;
    typedef enum logic [1:0] {M_LOW_PEAK, M_HIGH_PEAK, M_VALLEY} t_scan;

    t_state r_state;
    t_scan  r_mode;
    logic [CFG_W-1:0] r_bright_level, r_bright_offset, r_dark_offset;
    logic [CW-1:0]    r_total;
    logic [SUM_W-1:0] r_sum;
    logic             r_sat;
    logic [IW-1:0]    r_bin;
    logic             r_last;
    logic [IW-1:0]    r_idx;
    logic [4:0]       r_cnt;
    logic [CW-1:0]    r_rem;
    logic [SUM_W-1:0] r_quo;
    logic [CUMW-1:0]  r_cum;
    t_level           r_mean, r_median, r_hi;
    logic signed [EW-1:0] r_end;
    logic             r_first;
    logic [CW-1:0]    r_val;
    logic [IW-1:0]    r_best, r_pk1, r_pk2, r_vly;
    logic             r_ovalid;
    logic [THRESH_W-1:0] r_o_half;
    t_level           r_o_mean, r_o_median, r_o_pk1, r_o_pk2, r_o_vly;
    logic             r_o_ovf;

    logic           ram_we;
    logic [IW-1:0]  ram_waddr, ram_raddr, in_bin;
    logic [CW-1:0]  ram_wdata, ram_rdata;
    logic [PW-1:0]  px_ext;

    // division step
    logic [CW:0]      n_trial;
    logic             div_ge;
    logic [SUM_W-1:0] n_quo;
    // median step
    logic [CUMW-1:0]  n_cum;
    logic             med_hit;
    // limits
    t_level               lo, hi;
    logic signed [EW-1:0] lim1;
    // scan step
    logic                 take;
    logic signed [EW-1:0] nxt;
    logic [IW+1:0]        half;

    hvt_ram #(.WIDTH(CW), .DEPTH(BINS)) u_hist (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        px_ext = PW'(i_pix.pixel);
        in_bin = (px_ext > PW'(BINS - 1)) ? IW'(BINS - 1) : IW'(px_ext);

        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_raddr = r_idx;
        if (r_state == S_IDLE) begin
            ram_raddr = in_bin;
        end
        if (r_state == S_WR) begin
            ram_we    = 1'b1;
            ram_waddr = r_bin;
            ram_wdata = (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
        end
        if (r_state == S_CLR) begin
            ram_we = 1'b1;
        end

        n_trial = {r_rem, r_quo[SUM_W-1]};
        div_ge  = n_trial >= {1'b0, r_total};
        n_quo   = {r_quo[SUM_W-2:0], div_ge};

        n_cum   = r_cum + CUMW'(ram_rdata);
        med_hit = {n_cum, 1'b0} >= (CUMW + 1)'(r_total);

        lo   = (r_mean < r_median) ? r_mean : r_median;
        hi   = (r_mean > r_median) ? r_mean : r_median;
        lim1 = (lo >= r_bright_level)
             ? $signed(EW'(lo)) - $signed(EW'(r_bright_offset))
             : $signed(EW'(lo)) - $signed(EW'(r_dark_offset));

        take = r_first || ((r_mode == M_VALLEY) ? (ram_rdata < r_val)
                                                : (ram_rdata > r_val));
        nxt  = $signed(EW'(r_idx)) + $signed(EW'(1));

        half = (((IW + 2)'(r_vly) + (IW + 2)'(r_pk1)) >> 1)
             + (((IW + 2)'(r_vly) + (IW + 2)'(r_pk2)) >> 1);
    end

    assign i_pix.ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_ovalid;
    assign o_res.threshold_half = r_o_half;
    assign o_res.mean_level     = r_o_mean;
    assign o_res.median_level   = r_o_median;
    assign o_res.low_peak       = r_o_pk1;
    assign o_res.high_peak      = r_o_pk2;
    assign o_res.valley         = r_o_vly;
    assign o_res.overflow       = r_o_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLR;
            r_idx           <= '0;
            r_total         <= '0;
            r_sum           <= '0;
            r_sat           <= 1'b0;
            r_ovalid        <= 1'b0;
            r_bright_level  <= BRIGHT_LEVEL_RST;
            r_bright_offset <= BRIGHT_OFFSET_RST;
            r_dark_offset   <= DARK_OFFSET_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BRIGHT_LEVEL:  r_bright_level  <= i_cfg_data;
                    CFG_BRIGHT_OFFSET: r_bright_offset <= i_cfg_data;
                    CFG_DARK_OFFSET:   r_dark_offset   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IW'(BINS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_pix.valid) begin
                        r_bin  <= in_bin;
                        r_last <= i_pix.last;
                        if (r_total == CNT_MAX) r_sat <= 1'b1;
                        else r_total <= r_total + 1'b1;
                        if (({1'b0, r_sum} + (SUM_W + 1)'(in_bin)) > {1'b0, {SUM_W{1'b1}}}) begin
                            r_sum <= {SUM_W{1'b1}};
                            r_sat <= 1'b1;
                        end else begin
                            r_sum <= r_sum + SUM_W'(in_bin);
                        end
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if (ram_rdata == CNT_MAX) r_sat <= 1'b1;
                    r_rem <= '0;
                    r_quo <= r_sum;
                    r_cnt <= '0;
                    r_state <= r_last ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    r_rem <= div_ge ? CW'(n_trial - {1'b0, r_total}) : CW'(n_trial);
                    r_quo <= n_quo;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) begin
                        r_mean  <= (n_quo > SUM_W'(MEAN_MAX)) ? LEVEL_W'(MEAN_MAX)
                                                              : LEVEL_W'(n_quo);
                        r_idx   <= '0;
                        r_cum   <= '0;
                        r_state <= S_MRD;
                    end
                end
                S_MRD: r_state <= S_MEV;
                S_MEV: begin
                    r_cum <= n_cum;
                    if (med_hit) begin
                        r_median <= (int'(r_idx) > 255) ? 8'd255 : LEVEL_W'(r_idx);
                        r_state  <= S_LIM;
                    end else if (r_idx == IW'(BINS - 1)) begin
                        r_median <= LEVEL_W'(MEAN_MAX);
                        r_state  <= S_LIM;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_MRD;
                    end
                end
                S_LIM: begin
                    // lower peak over [0, lim1), end capped at the bin count
                    r_hi    <= hi;
                    r_idx   <= '0;
                    r_end   <= (lim1 > $signed(EW'(BINS))) ? $signed(EW'(BINS)) : lim1;
                    r_first <= 1'b1;
                    r_mode  <= M_LOW_PEAK;
                    r_state <= S_SRD;
                end
                S_SRD: r_state <= S_SEV;
                S_SEV: begin
                    r_first <= 1'b0;
                    if (take) begin
                        r_val  <= ram_rdata;
                        r_best <= r_idx;
                    end
                    if (nxt < r_end) begin
                        r_idx   <= IW'(nxt);
                        r_state <= S_SRD;
                    end else begin
                        r_first <= 1'b1;
                        r_state <= S_SRD;
                        case (r_mode)
                            M_LOW_PEAK: begin
                                r_pk1  <= take ? r_idx : r_best;
                                r_idx  <= IW'(r_hi);
                                r_end  <= $signed(EW'(BINS));
                                r_mode <= M_HIGH_PEAK;
                            end
                            M_HIGH_PEAK: begin
                                r_pk2  <= take ? r_idx : r_best;
                                r_idx  <= r_pk1;
                                r_end  <= $signed(EW'(r_hi));
                                r_mode <= M_VALLEY;
                            end
                            default: begin
                                r_vly   <= take ? r_idx : r_best;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_ovalid   <= 1'b1;
                        r_o_half   <= THRESH_W'(half);
                        r_o_mean   <= r_mean;
                        r_o_median <= r_median;
                        r_o_pk1    <= LEVEL_W'(r_pk1);
                        r_o_pk2    <= LEVEL_W'(r_pk2);
                        r_o_vly    <= LEVEL_W'(r_vly);
                        r_o_ovf    <= r_sat;
                        r_total    <= '0;
                        r_sum      <= '0;
                        r_sat      <= 1'b0;
                        r_idx      <= '0;
                        r_state    <= S_CLR;
                    end
                end
                default: r_state <= S_CLR;
            endcase
        end
    end
endmodule
